// File: rtl/tcfu_pkg.sv
// ----------------------------------------------------------------------------
// tcfu_pkg
// Types, constants and helper functions for the trilinear constraint force
// update core: item structs, saturating fixed-point arithmetic and the
// micro-op program that drives the shared multiplier.
// ----------------------------------------------------------------------------
package tcfu_pkg;

	// Number format: signed fixed point, VALUE_WIDTH bits, FRACTION_BITS fraction
	localparam int VALUE_WIDTH   = 32;
	localparam int FRACTION_BITS = 16;
	localparam int WEIGHT_W      = 17;
	localparam int PROD_W        = 2 * VALUE_WIDTH + 1;
	localparam int NUM_CORNERS   = 8;
	localparam int CORNER_W      = $clog2(NUM_CORNERS);
	localparam int RF_DEPTH      = 2 * NUM_CORNERS;
	localparam int RF_AW         = $clog2(RF_DEPTH);
	localparam int NUM_OPS       = 15;
	localparam int OP_W          = $clog2(NUM_OPS);

	localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic [VALUE_WIDTH:0]   WEIGHT_ONE = (VALUE_WIDTH+1)'(1) << FRACTION_BITS;
	localparam logic [OP_W-1:0]        LAST_OP = OP_W'(NUM_OPS - 1);
	localparam logic [CORNER_W-1:0]    LAST_CORNER = CORNER_W'(NUM_CORNERS - 1);

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] corner_value;
		logic [VALUE_WIDTH-1:0] force_in;
		logic [WEIGHT_W-1:0]    weight_x;
		logic [WEIGHT_W-1:0]    weight_y;
		logic [WEIGHT_W-1:0]    weight_z;
		logic [VALUE_WIDTH-1:0] scale_factor;
		logic                   last_corner;
	} corner_item_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] force_out;
		logic [CORNER_W-1:0]    corner_index;
		logic                   last_result;
	} result_item_t;

	// Micro-op kinds of the shared unit
	typedef enum logic [1:0] {
		OP_LERP  = 2'd0,   // dst_a = a + (b - a) * w
		OP_SCALE = 2'd1,   // dst_a = a * scale
		OP_SPLIT = 2'd2    // dst_a = a * w, dst_b = a - a * w
	} op_kind_t;

	typedef enum logic [1:0] {
		W_X = 2'd0,
		W_Y = 2'd1,
		W_Z = 2'd2
	} wsel_t;

	typedef struct packed {
		op_kind_t         kind;
		logic [RF_AW-1:0] src_a;
		logic [RF_AW-1:0] src_b;
		wsel_t            wsel;
		logic [RF_AW-1:0] dst_a;
		logic [RF_AW-1:0] dst_b;
	} uop_t;

	// Saturating add in VALUE_WIDTH bits
	function automatic logic [VALUE_WIDTH-1:0] sat_add(input logic [VALUE_WIDTH-1:0] a,
		input logic [VALUE_WIDTH-1:0] b);
		logic [VALUE_WIDTH:0] s;
		s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
		if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
			return s[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
		end
		return s[VALUE_WIDTH-1:0];
	endfunction

	// Saturating subtract a - b in VALUE_WIDTH bits
	function automatic logic [VALUE_WIDTH-1:0] sat_sub(input logic [VALUE_WIDTH-1:0] a,
		input logic [VALUE_WIDTH-1:0] b);
		logic [VALUE_WIDTH:0] s;
		s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
		if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
			return s[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
		end
		return s[VALUE_WIDTH-1:0];
	endfunction

	// Drop the fraction bits of an exact product (floor) and saturate
	function automatic logic [VALUE_WIDTH-1:0] sat_shift(input logic [PROD_W-1:0] p);
		logic [PROD_W-FRACTION_BITS-VALUE_WIDTH:0] hi;
		hi = p[PROD_W-1:FRACTION_BITS+VALUE_WIDTH-1];
		if ((&hi) || !(|hi)) begin
			return p[FRACTION_BITS+VALUE_WIDTH-1:FRACTION_BITS];
		end
		return p[PROD_W-1] ? VAL_MIN : VAL_MAX;
	endfunction

	// Clamp a raw weight to one
	function automatic logic [VALUE_WIDTH:0] clamp_weight(input logic [WEIGHT_W-1:0] raw);
		logic [VALUE_WIDTH:0] w;
		w = (VALUE_WIDTH+1)'(raw);
		return (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
	endfunction

	// Scratch file: 0..7 hold corners, 8..15 hold intermediate values.
	// Interpolate, scale, then split back by the transposed weights; the
	// final splits leave the eight shares in the temporary half.
	function automatic uop_t uop_rom(input logic [OP_W-1:0] idx);
		case (idx)
			4'd0:    return '{OP_LERP,  4'd0,  4'd4,  W_X, 4'd8,  4'd0};
			4'd1:    return '{OP_LERP,  4'd1,  4'd5,  W_X, 4'd9,  4'd0};
			4'd2:    return '{OP_LERP,  4'd2,  4'd6,  W_X, 4'd10, 4'd0};
			4'd3:    return '{OP_LERP,  4'd3,  4'd7,  W_X, 4'd11, 4'd0};
			4'd4:    return '{OP_LERP,  4'd8,  4'd9,  W_Z, 4'd12, 4'd0};
			4'd5:    return '{OP_LERP,  4'd10, 4'd11, W_Z, 4'd13, 4'd0};
			4'd6:    return '{OP_LERP,  4'd12, 4'd13, W_Y, 4'd14, 4'd0};
			4'd7:    return '{OP_SCALE, 4'd14, 4'd0,  W_X, 4'd15, 4'd0};
			4'd8:    return '{OP_SPLIT, 4'd15, 4'd0,  W_Y, 4'd8,  4'd9};
			4'd9:    return '{OP_SPLIT, 4'd8,  4'd0,  W_Z, 4'd10, 4'd11};
			4'd10:   return '{OP_SPLIT, 4'd9,  4'd0,  W_Z, 4'd12, 4'd13};
			4'd11:   return '{OP_SPLIT, 4'd13, 4'd0,  W_X, 4'd14, 4'd15};
			4'd12:   return '{OP_SPLIT, 4'd12, 4'd0,  W_X, 4'd8,  4'd9};
			4'd13:   return '{OP_SPLIT, 4'd11, 4'd0,  W_X, 4'd13, 4'd12};
			4'd14:   return '{OP_SPLIT, 4'd10, 4'd0,  W_X, 4'd11, 4'd10};
			default: return '{OP_SCALE, 4'd0,  4'd0,  W_X, 4'd8,  4'd0};
		endcase
	endfunction

	// Scratch location of each corner's share after the last split
	function automatic logic [RF_AW-1:0] share_addr(input logic [CORNER_W-1:0] corner);
		case (corner)
			3'd0:    return 4'd15;
			3'd1:    return 4'd9;
			3'd2:    return 4'd12;
			3'd3:    return 4'd10;
			3'd4:    return 4'd14;
			3'd5:    return 4'd8;
			3'd6:    return 4'd13;
			3'd7:    return 4'd11;
			default: return 4'd15;
		endcase
	endfunction

endpackage

// File: rtl/trilinear_constraint_force_update_core.sv
// ----------------------------------------------------------------------------
// trilinear_constraint_force_update_core
// Trilinear interpolation of one displacement component over a cell, scale,
// and transposed spread of the result back onto the eight corner forces.
// ----------------------------------------------------------------------------
// Usage:
//  The input channel (item_valid / item_stall / item) takes one corner per
//  item: displacement and current force, stored in the slot given by an
//  internal corner count. The item with last_corner set also supplies the
//  weights and the scale and starts the computation.
//  Ordinary corner items are taken at one item per cycle. After the last item
//  the block stalls its input while one shared multiplier runs fifteen
//  micro-ops (seven lerps, one scale and seven splits, each reading its
//  operands, multiplying and writing back; a split also writes a remainder)
//  over a scratch file with one read and one write port, then while it emits
//  eight result items, corners 0 to 7, one per cycle while result_stall is
//  low; last_result marks corner 7. The throughput is set by the one
//  multiplier and the one read port of the scratch file.
//  A result waits in the output register while result_stall is high; the
//  sequencer holds until it is taken. The input is taken again as soon as
//  the eighth result is loaded into the output register.
//  Reset clears the corner count and the sequencer; stored corners and
//  forces are undefined until written.
// ----------------------------------------------------------------------------
module trilinear_constraint_force_update_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  tcfu_pkg::corner_item_t item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output tcfu_pkg::result_item_t result
);
	import tcfu_pkg::*;

	typedef enum logic [6:0] {
		ST_LOAD = 7'b0000001,
		ST_RD_A = 7'b0000010,
		ST_RD_B = 7'b0000100,
		ST_MUL  = 7'b0001000,
		ST_ACC  = 7'b0010000,
		ST_LO   = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t                   state_q;
	logic [CORNER_W-1:0]      count_q;
	logic [OP_W-1:0]          op_q;
	logic [CORNER_W-1:0]      out_idx_q;

	logic [VALUE_WIDTH-1:0]   rf_q [RF_DEPTH];
	logic [VALUE_WIDTH-1:0]   force_q [NUM_CORNERS];

	logic [VALUE_WIDTH:0]     wx_q, wy_q, wz_q, scale_q;
	logic [VALUE_WIDTH-1:0]   a_q, d_q, m_q;
	logic signed [PROD_W-1:0] prod_q;

	logic                     res_valid_q;
	result_item_t             res_q;

	logic                     item_accept;
	logic                     out_load;
	uop_t                     uop;
	logic [RF_AW-1:0]         rd_addr;
	logic [VALUE_WIDTH-1:0]   rd_data;
	logic                     rf_we;
	logic [RF_AW-1:0]         rf_wa;
	logic [VALUE_WIDTH-1:0]   rf_wd;
	logic [VALUE_WIDTH-1:0]   mul_res;
	logic [VALUE_WIDTH:0]     mul_b;

	assign item_stall   = (state_q != ST_LOAD);
	assign item_accept  = item_valid && !item_stall;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign uop     = uop_rom(op_q);
	assign mul_res = sat_shift(prod_q);
	assign out_load = (state_q == ST_OUT) && (!res_valid_q || !result_stall);

	// Select the single scratch read address
	always_comb begin
		case (state_q)
			ST_RD_A: rd_addr = uop.src_a;
			ST_RD_B: rd_addr = uop.src_b;
			ST_OUT:  rd_addr = share_addr(out_idx_q);
			default: rd_addr = uop.src_a;
		endcase
	end
	assign rd_data = rf_q[rd_addr];

	// Pick the second multiplier operand
	always_comb begin
		if (uop.kind == OP_SCALE) begin
			mul_b = scale_q;
		end else begin
			case (uop.wsel)
				W_X:     mul_b = wx_q;
				W_Y:     mul_b = wy_q;
				W_Z:     mul_b = wz_q;
				default: mul_b = wx_q;
			endcase
		end
	end

	// Steer the single scratch write port
	always_comb begin
		rf_we = 1'b0;
		rf_wa = uop.dst_a;
		rf_wd = mul_res;
		case (state_q)
			ST_LOAD: begin
				rf_we = item_accept;
				rf_wa = {1'b0, count_q};
				rf_wd = item.corner_value;
			end
			ST_ACC: begin
				rf_we = 1'b1;
				rf_wa = uop.dst_a;
				rf_wd = (uop.kind == OP_LERP) ? sat_add(mul_res, a_q) : mul_res;
			end
			ST_LO: begin
				rf_we = 1'b1;
				rf_wa = uop.dst_b;
				rf_wd = sat_sub(a_q, m_q);
			end
			default: begin
				rf_we = 1'b0;
			end
		endcase
	end

	// Scratch file and force store
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_q[rf_wa] <= rf_wd;
		end
		if (item_accept) begin
			force_q[count_q] <= item.force_in;
		end
	end

	// Latch weights and scale from the last corner item
	always_ff @(posedge clk) begin
		if (item_accept && item.last_corner) begin
			wx_q    <= clamp_weight(item.weight_x);
			wy_q    <= clamp_weight(item.weight_y);
			wz_q    <= clamp_weight(item.weight_z);
			scale_q <= {item.scale_factor[VALUE_WIDTH-1], item.scale_factor};
		end
	end

	// Shared datapath: operand fetch, difference, multiply, shift
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RD_A: begin
				a_q <= rd_data;
			end
			ST_RD_B: begin
				d_q <= (uop.kind == OP_LERP) ? sat_sub(rd_data, a_q) : a_q;
			end
			ST_MUL: begin
				prod_q <= signed'(d_q) * signed'(mul_b);
			end
			ST_ACC: begin
				m_q <= mul_res;
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			op_q      <= '0;
			out_idx_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (item_accept) begin
						if (item.last_corner) begin
							count_q <= '0;
							op_q    <= '0;
							state_q <= ST_RD_A;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_RD_A: state_q <= ST_RD_B;
				ST_RD_B: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_ACC;
				ST_ACC, ST_LO: begin
					if (state_q == ST_ACC && uop.kind == OP_SPLIT) begin
						state_q <= ST_LO;
					end else if (op_q == LAST_OP) begin
						out_idx_q <= '0;
						state_q   <= ST_OUT;
					end else begin
						op_q    <= op_q + 1'b1;
						state_q <= ST_RD_A;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_idx_q <= out_idx_q + 1'b1;
						if (out_idx_q == LAST_CORNER) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q.force_out    <= sat_sub(force_q[out_idx_q], rd_data);
			res_q.corner_index <= out_idx_q;
			res_q.last_result  <= (out_idx_q == LAST_CORNER);
		end
	end

	// Checks
	a_last_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(item_accept && item.last_corner) |=> (item_stall && count_q == '0))
		else $error("last corner item did not start a run");

	a_last_flag_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last_result == (result.corner_index == LAST_CORNER)))
		else $error("last_result does not match corner index");

	a_index_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && !result.last_result && result_valid == 1'b1)
		##1 result_valid |-> (result.corner_index == $past(result.corner_index) + 1'b1))
		else $error("result corner index skipped or repeated");

	a_no_input_while_computing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !item_accept)
		else $error("item accepted during computation");

endmodule

// File: tb/sv/trilinear_constraint_force_update_core_tb.sv
// ----------------------------------------------------------------------------
// trilinear_constraint_force_update_core_tb
// Self-checking bench for the corner force update core. A short directed
// table covers zero and saturated cells, clamped and zero weights, and an
// early last mark. Random cells follow: mostly full cells of eight corners,
// some early and late last marks. A local fixed-point predictor supplies the
// eight expected corner forces of each cell. Both channels idle at random,
// and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module trilinear_constraint_force_update_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcfu_pkg::*;

	localparam int ITEM_TOTAL = 320;
	localparam int QUIET_TAIL = 40;
	localparam int HOLD_AFTER = 100;
	localparam int HOLD_CYCLES = 500;

	// Signed value and a wide signed scratch type for exact products
	typedef logic signed [VALUE_WIDTH-1:0]   q_t;
	typedef logic signed [2*VALUE_WIDTH+1:0] qw_t;

	localparam qw_t Q_HI  = (qw_t'(1) <<< (VALUE_WIDTH - 1)) - 1;
	localparam qw_t Q_LO  = -Q_HI - 1;
	localparam qw_t Q_ONE = qw_t'(1) <<< FRACTION_BITS;

	typedef struct {
		corner_item_t it;
		bit           pinned;
		q_t           want;
	} stim_row_t;

	logic         clk;
	logic         arst_n;
	logic         item_valid;
	logic         item_stall;
	corner_item_t item;
	logic         result_valid;
	logic         result_stall;
	result_item_t result;

	// Predictor state: stored corners, forces, typed-in results, slot pointer
	q_t                disp_slot [NUM_CORNERS];
	q_t                force_slot [NUM_CORNERS];
	bit                pin_on [NUM_CORNERS];
	q_t                pin_val [NUM_CORNERS];
	logic [CORNER_W-1:0] slot_ptr;

	result_item_t force_updates_due [$];
	int           fault_count;
	int           items_taken;
	bit           quiet;
	bit           hold_req;
	bit           hold_done;

	trilinear_constraint_force_update_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Clock: 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Saturating fixed-point arithmetic on wide signed integers
	function automatic q_t q_clip(input qw_t v);
		if (v > Q_HI) begin
			return q_t'(Q_HI);
		end
		if (v < Q_LO) begin
			return q_t'(Q_LO);
		end
		return q_t'(v);
	endfunction

	function automatic q_t q_add(input q_t a, input q_t b);
		qw_t wa;
		qw_t wb;
		wa = a;
		wb = b;
		return q_clip(wa + wb);
	endfunction

	function automatic q_t q_sub(input q_t a, input q_t b);
		qw_t wa;
		qw_t wb;
		wa = a;
		wb = b;
		return q_clip(wa - wb);
	endfunction

	// Exact product, floor by the fraction bits, then saturate
	function automatic q_t q_mul(input qw_t a, input qw_t b);
		qw_t p;
		p = a * b;
		return q_clip(p >>> FRACTION_BITS);
	endfunction

	function automatic q_t q_lerp(input q_t lo, input q_t hi, input qw_t w);
		return q_add(q_mul(q_sub(hi, lo), w), lo);
	endfunction

	function automatic qw_t q_weight(input logic [WEIGHT_W-1:0] raw);
		qw_t w;
		w = raw;
		return (w > Q_ONE) ? Q_ONE : w;
	endfunction

	// Store one accepted corner; on the last mark, queue the eight updates
	task automatic apply_constraint(input corner_item_t it, input bit pin, input q_t want);
		q_t           c [NUM_CORNERS];
		q_t           sh [NUM_CORNERS];
		q_t           e00, e01, e10, e11, f0, f1, g, s;
		q_t           t0, t1, t00, t01, t10, t11;
		qw_t          wx, wy, wz;
		result_item_t r;
		disp_slot[slot_ptr]  = it.corner_value;
		force_slot[slot_ptr] = it.force_in;
		pin_on[slot_ptr]     = pin;
		pin_val[slot_ptr]    = want;
		if (!it.last_corner) begin
			slot_ptr = slot_ptr + 1'b1;
			return;
		end
		slot_ptr = '0;
		wx = q_weight(it.weight_x);
		wy = q_weight(it.weight_y);
		wz = q_weight(it.weight_z);
		for (int i = 0; i < NUM_CORNERS; i++) begin
			c[i] = disp_slot[i];
		end
		// interpolate along x, then z, then y
		e00 = q_lerp(c[0], c[4], wx);
		e01 = q_lerp(c[1], c[5], wx);
		e10 = q_lerp(c[2], c[6], wx);
		e11 = q_lerp(c[3], c[7], wx);
		f0  = q_lerp(e00, e01, wz);
		f1  = q_lerp(e10, e11, wz);
		g   = q_lerp(f0, f1, wy);
		s   = q_mul(g, q_t'(it.scale_factor));
		// spread back by the transposed weights
		t1  = q_mul(s, wy);
		t0  = q_sub(s, t1);
		t11 = q_mul(t1, wz);
		t10 = q_sub(t1, t11);
		t01 = q_mul(t0, wz);
		t00 = q_sub(t0, t01);
		sh[4] = q_mul(t00, wx);
		sh[0] = q_sub(t00, sh[4]);
		sh[5] = q_mul(t01, wx);
		sh[1] = q_sub(t01, sh[5]);
		sh[6] = q_mul(t10, wx);
		sh[2] = q_sub(t10, sh[6]);
		sh[7] = q_mul(t11, wx);
		sh[3] = q_sub(t11, sh[7]);
		for (int i = 0; i < NUM_CORNERS; i++) begin
			r.force_out    = pin_on[i] ? pin_val[i] : q_sub(force_slot[i], sh[i]);
			r.corner_index = CORNER_W'(i);
			r.last_result  = (i == NUM_CORNERS - 1);
			force_updates_due.push_back(r);
			pin_on[i] = 1'b0;
		end
	endtask

	// Offer one item, hold it until taken, then maybe idle a burst
	task automatic offer(input corner_item_t it, input bit pin, input q_t want);
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		apply_constraint(it, pin, want);
		items_taken++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	function automatic q_t pick_value();
		case ($urandom_range(0, 9))
			0:       return q_t'(VAL_MAX);
			1:       return q_t'(VAL_MIN);
			2:       return '0;
			3, 4, 5: return q_t'($urandom);
			default: return q_t'(int'($urandom_range(0, 262144)) - 131072);
		endcase
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return WEIGHT_W'(Q_ONE);
			2:       return WEIGHT_W'($urandom_range(65537, 131071));
			default: return WEIGHT_W'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic stim_row_t row(input q_t disp, input q_t frc,
		input logic [WEIGHT_W-1:0] wx, input logic [WEIGHT_W-1:0] wy,
		input logic [WEIGHT_W-1:0] wz, input q_t sc, input logic last,
		input bit pin, input q_t want);
		stim_row_t r;
		r.it.corner_value = disp;
		r.it.force_in     = frc;
		r.it.weight_x     = wx;
		r.it.weight_y     = wy;
		r.it.weight_z     = wz;
		r.it.scale_factor = sc;
		r.it.last_corner  = last;
		r.pinned          = pin;
		r.want            = want;
		return r;
	endfunction

	// Check each taken result against the oldest expected update
	always @(posedge clk) begin : result_check
		result_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (force_updates_due.size() == 0) begin
				$error("unexpected result: corner_index %0d force_out %0d",
					result.corner_index, $signed(result.force_out));
				fault_count++;
			end else begin
				want = force_updates_due.pop_front();
				if (result.force_out !== want.force_out) begin
					$error("force_out: expected %0d, got %0d",
						$signed(want.force_out), $signed(result.force_out));
					fault_count++;
				end
				if (result.corner_index !== want.corner_index) begin
					$error("corner_index: expected %0d, got %0d",
						want.corner_index, result.corner_index);
					fault_count++;
				end
				if (result.last_result !== want.last_result) begin
					$error("last_result: expected %0d, got %0d",
						want.last_result, result.last_result);
					fault_count++;
				end
			end
		end
	end

	// Result side: stall bursts, open stretches and one long hold-off
	initial begin : result_side
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(0, 40)) @(posedge clk);
			end
		end
	end

	// Item side: reset, directed table, random cells, drain
	initial begin : item_side
		stim_row_t    directed [$];
		corner_item_t it;
		int           span;
		int           pick;
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		item        = '0;
		slot_ptr    = '0;
		fault_count = 0;
		items_taken = 0;
		quiet       = 1'b0;
		hold_req    = 1'b0;
		hold_done   = 1'b0;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			pin_on[i] = 1'b0;
		end

		// zero displacement: no share, every force passes through unchanged
		directed.push_back(row('0, VAL_MIN, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, VAL_MIN,
			1'b0, 1'b1, VAL_MIN));
		directed.push_back(row('0, VAL_MAX, '0, '0, '0, VAL_MAX, 1'b0, 1'b1, VAL_MAX));
		directed.push_back(row('0, '0, '0, '0, '0, '0, 1'b0, 1'b1, '0));
		directed.push_back(row('0, 32'sd1, '0, '0, '0, '0, 1'b0, 1'b1, 32'sd1));
		directed.push_back(row('0, -32'sd1, '0, '0, '0, '0, 1'b0, 1'b1, -32'sd1));
		directed.push_back(row('0, 32'h0001_0000, '0, '0, '0, '0, 1'b0, 1'b1,
			32'h0001_0000));
		directed.push_back(row('0, 32'h5555_5555, '0, '0, '0, '0, 1'b0, 1'b1,
			32'h5555_5555));
		directed.push_back(row('0, 32'hAAAA_AAAA, 17'h10000, 17'h08000, 17'h1FFFF, VAL_MAX,
			1'b1, 1'b1, 32'hAAAA_AAAA));
		// full-scale displacement, weights above one: corner 7 takes it all
		directed.push_back(row(VAL_MAX, 32'h1234_5678, '0, '0, '0, '0, 1'b0, 1'b1,
			32'h1234_5678));
		directed.push_back(row(VAL_MAX, VAL_MAX, '0, '0, '0, '0, 1'b0, 1'b1, VAL_MAX));
		directed.push_back(row(VAL_MAX, VAL_MIN, '0, '0, '0, '0, 1'b0, 1'b1, VAL_MIN));
		directed.push_back(row(VAL_MAX, '0, '0, '0, '0, '0, 1'b0, 1'b1, '0));
		directed.push_back(row(VAL_MAX, 32'hFFFF_0000, '0, '0, '0, '0, 1'b0, 1'b1,
			32'hFFFF_0000));
		directed.push_back(row(VAL_MAX, 32'h0000_FFFF, '0, '0, '0, '0, 1'b0, 1'b1,
			32'h0000_FFFF));
		directed.push_back(row(VAL_MAX, -32'sd1, '0, '0, '0, '0, 1'b0, 1'b1, -32'sd1));
		directed.push_back(row(VAL_MAX, VAL_MIN, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, VAL_MAX,
			1'b1, 1'b1, VAL_MIN));
		// early last mark, zero weights: corner 0 takes the saturated share
		directed.push_back(row(VAL_MIN, '0, '0, '0, '0, '0, 1'b0, 1'b1, 32'h8000_0001));
		directed.push_back(row(VAL_MIN, VAL_MAX, '0, '0, '0, '0, 1'b0, 1'b1, VAL_MAX));
		directed.push_back(row(VAL_MIN, VAL_MIN, '0, '0, '0, '0, 1'b0, 1'b1, VAL_MIN));
		directed.push_back(row(VAL_MIN, 32'h0C0F_FEE0, '0, '0, '0, VAL_MIN, 1'b1, 1'b1,
			32'h0C0F_FEE0));
		// single-corner cell with mid weights
		directed.push_back(row(32'h0003_0000, 32'h0001_0000, 17'h08000, 17'h04000, 17'h0C000,
			32'h0002_0000, 1'b1, 1'b0, '0));

		// hold reset, then release it
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			offer(directed[i].it, directed[i].pinned, directed[i].want);
		end

		// random cells: mostly full, some with early or late last marks
		while (items_taken < ITEM_TOTAL) begin
			pick = $urandom_range(0, 9);
			if (pick < 8) begin
				span = NUM_CORNERS;
			end else if (pick == 8) begin
				span = $urandom_range(1, NUM_CORNERS - 1);
			end else begin
				span = $urandom_range(NUM_CORNERS + 1, 14);
			end
			for (int k = 0; k < span; k++) begin
				it.corner_value = pick_value();
				it.force_in     = pick_value();
				it.weight_x     = pick_weight();
				it.weight_y     = pick_weight();
				it.weight_z     = pick_weight();
				it.scale_factor = pick_value();
				it.last_corner  = (k == span - 1);
				if (items_taken >= HOLD_AFTER) begin
					hold_req = 1'b1;
				end
				quiet = (items_taken >= ITEM_TOTAL - QUIET_TAIL);
				offer(it, 1'b0, '0);
			end
		end
		item_valid <= 1'b0;

		// drain, then leave room for any stray result
		while (force_updates_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (120) @(posedge clk);
		if (fault_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: trilinear_constraint_force_update_core.f
rtl/tcfu_pkg.sv
rtl/trilinear_constraint_force_update_core.sv
tb/sv/trilinear_constraint_force_update_core_tb.sv
